@@ src/buzzer_backlight_alarm_sequencer_macros.svh @@
// Assertion macros for the checker file of the alarm sequencer.
`ifndef BUZZER_BACKLIGHT_ALARM_SEQUENCER_MACROS_SVH
`define BUZZER_BACKLIGHT_ALARM_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication that is checked at every edge, reset included.
`define BBAS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ src/bbas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm sequencer package
// Item kinds, effect flag positions, register indexes and shared types.
// ----------------------------------------------------------------------------
package bbas_pkg;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_FAST_BEEP   = 3'd1,
        KIND_SLOW_BEEP   = 3'd2,
        KIND_BEEP_BEGIN  = 3'd3,
        KIND_BEEP_END    = 3'd4,
        KIND_FLASH       = 3'd5,
        KIND_BLINK_BEGIN = 3'd6,
        KIND_BLINK_END   = 3'd7
    } t_kind;

    localparam int F_BEEP_ON    = 0;
    localparam int F_BLINK_ON   = 1;
    localparam int F_BEEP_CONT  = 2;
    localparam int F_BLINK_CONT = 3;
    localparam int F_BEEP_SYNC  = 4;
    localparam int F_BLINK_SYNC = 5;
    localparam int F_BEEP_PHASE = 6;
    localparam int FLAG_W       = 7;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TIME_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BEEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BEEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] fast_beep_ms;
        logic [CFG_W-1:0] slow_beep_ms;
        logic [CFG_W-1:0] flash_ms;
        logic [CFG_W-1:0] half_period_ms;
    } t_cfg;

    typedef struct packed {
        logic buzzer_level;
        logic backlight_level;
        logic timer_running;
        logic command_accepted;
    } t_result;

endpackage
`default_nettype wire

@@ src/bbas_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm sequencer configuration registers
// Holds the beep, flash and half-period durations written over the port.
// ----------------------------------------------------------------------------
module bbas_cfg
    import bbas_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_beep_ms   <= 16'd50;
            r_cfg.slow_beep_ms   <= 16'd200;
            r_cfg.flash_ms       <= 16'd100;
            r_cfg.half_period_ms <= 16'd250;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FAST_BEEP:   r_cfg.fast_beep_ms   <= i_cfg_data;
                CFG_SLOW_BEEP:   r_cfg.slow_beep_ms   <= i_cfg_data;
                CFG_FLASH:       r_cfg.flash_ms       <= i_cfg_data;
                CFG_HALF_PERIOD: r_cfg.half_period_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ src/bbas_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm sequencer core
// Effect state and the single-pass update for one command or tick.
// ----------------------------------------------------------------------------
module bbas_core
    import bbas_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_kind             i_kind,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    logic              r_running;
    logic              r_cont;
    logic [FLAG_W-1:0] r_flags;
    logic [TIME_W-1:0] r_beep_stamp;
    logic [TIME_W-1:0] r_blink_stamp;
    logic              r_buzzer;
    logic              r_backlight;

    logic              n_running;
    logic              n_cont;
    logic [FLAG_W-1:0] n_flags;
    logic [TIME_W-1:0] n_beep_stamp;
    logic [TIME_W-1:0] n_blink_stamp;
    logic              n_buzzer;
    logic              n_backlight;
    logic              n_ok;
    logic [TIME_W-1:0] beep_age;
    logic [TIME_W-1:0] blink_age;
    logic [TIME_W-1:0] half_period;

    assign half_period = {{(TIME_W - CFG_W){1'b0}}, i_cfg.half_period_ms};

    always_comb begin
        n_running     = r_running;
        n_cont        = r_cont;
        n_flags       = r_flags;
        n_beep_stamp  = r_beep_stamp;
        n_blink_stamp = r_blink_stamp;
        n_buzzer      = r_buzzer;
        n_backlight   = r_backlight;
        n_ok          = 1'b0;
        beep_age      = '0;
        blink_age     = '0;

        case (i_kind)
            KIND_TICK: begin
                if (r_running) begin
                    n_ok = 1'b1;
                    if (r_cont) begin
                        if (r_flags[F_BEEP_ON]) begin
                            if (!r_flags[F_BEEP_SYNC]) begin
                                if (r_flags[F_BLINK_CONT] && r_flags[F_BLINK_SYNC]) begin
                                    n_beep_stamp = r_blink_stamp;
                                end
                                n_flags[F_BEEP_SYNC] = 1'b1;
                            end
                            beep_age = i_now_ms - n_beep_stamp;
                            if (beep_age > half_period) begin
                                n_flags[F_BEEP_PHASE] = ~n_flags[F_BEEP_PHASE];
                                n_beep_stamp          = i_now_ms;
                            end
                            if (n_flags[F_BEEP_PHASE]) begin
                                n_buzzer = ~r_buzzer;
                            end
                        end else begin
                            n_buzzer = 1'b0;
                        end
                        if (r_flags[F_BLINK_ON]) begin
                            if (!r_flags[F_BLINK_SYNC]) begin
                                if (n_flags[F_BEEP_CONT]) begin
                                    n_blink_stamp = n_beep_stamp;
                                end
                                n_flags[F_BLINK_SYNC] = 1'b1;
                            end
                            blink_age = i_now_ms - n_blink_stamp;
                            if (blink_age > half_period) begin
                                n_backlight   = ~r_backlight;
                                n_blink_stamp = i_now_ms;
                            end
                        end else begin
                            n_backlight = 1'b1;
                        end
                    end else begin
                        if (r_flags[F_BEEP_ON]) begin
                            if (r_flags[F_BEEP_SYNC]) begin
                                n_buzzer = ~r_buzzer;
                                if (i_now_ms >= r_beep_stamp) begin
                                    n_buzzer            = 1'b1;
                                    n_flags[F_BEEP_ON] = 1'b0;
                                end
                            end else begin
                                n_beep_stamp         = r_beep_stamp + i_now_ms;
                                n_flags[F_BEEP_SYNC] = 1'b1;
                                n_buzzer             = ~r_buzzer;
                            end
                        end else begin
                            n_buzzer = 1'b0;
                        end
                        if (r_flags[F_BLINK_ON]) begin
                            if (r_flags[F_BLINK_SYNC]) begin
                                if (i_now_ms >= r_blink_stamp) begin
                                    n_backlight         = 1'b1;
                                    n_flags[F_BLINK_ON] = 1'b0;
                                end
                            end else begin
                                n_blink_stamp         = r_blink_stamp + i_now_ms;
                                n_backlight           = 1'b0;
                                n_flags[F_BLINK_SYNC] = 1'b1;
                            end
                        end else begin
                            n_backlight = 1'b1;
                        end
                    end
                    if (!r_flags[F_BEEP_ON] && !r_flags[F_BLINK_ON]) begin
                        n_running = 1'b0;
                    end
                end
            end
            KIND_FAST_BEEP, KIND_SLOW_BEEP: begin
                if (!r_running || (!r_cont && !r_flags[F_BEEP_ON])) begin
                    n_cont               = 1'b0;
                    n_beep_stamp         = {{(TIME_W - CFG_W){1'b0}},
                                            (i_kind == KIND_FAST_BEEP) ?
                                            i_cfg.fast_beep_ms : i_cfg.slow_beep_ms};
                    n_flags[F_BEEP_ON]   = 1'b1;
                    n_flags[F_BEEP_SYNC] = 1'b0;
                    n_running            = 1'b1;
                    n_ok                 = 1'b1;
                end
            end
            KIND_BEEP_BEGIN: begin
                if (!r_running || (r_cont && !r_flags[F_BEEP_CONT])) begin
                    n_cont                = 1'b1;
                    n_beep_stamp          = '0;
                    n_flags[F_BEEP_ON]    = 1'b1;
                    n_flags[F_BEEP_CONT]  = 1'b1;
                    n_flags[F_BEEP_PHASE] = 1'b1;
                    n_flags[F_BEEP_SYNC]  = 1'b0;
                    n_running             = 1'b1;
                    n_ok                  = 1'b1;
                end
            end
            KIND_BEEP_END: begin
                if (r_running && r_cont && r_flags[F_BEEP_CONT]) begin
                    n_flags[F_BEEP_ON]   = 1'b0;
                    n_flags[F_BEEP_CONT] = 1'b0;
                    n_running            = 1'b0;
                    n_ok                 = 1'b1;
                end
            end
            KIND_FLASH: begin
                if (!r_running || (!r_cont && !r_flags[F_BLINK_ON])) begin
                    n_cont                = 1'b0;
                    n_blink_stamp         = {{(TIME_W - CFG_W){1'b0}}, i_cfg.flash_ms};
                    n_flags[F_BLINK_ON]   = 1'b1;
                    n_flags[F_BLINK_SYNC] = 1'b0;
                    n_running             = 1'b1;
                    n_ok                  = 1'b1;
                end
            end
            KIND_BLINK_BEGIN: begin
                if (!r_running || (r_cont && !r_flags[F_BLINK_CONT])) begin
                    n_cont                = 1'b1;
                    n_blink_stamp         = '0;
                    n_flags[F_BLINK_ON]   = 1'b1;
                    n_flags[F_BLINK_CONT] = 1'b1;
                    n_flags[F_BLINK_SYNC] = 1'b0;
                    n_running             = 1'b1;
                    n_ok                  = 1'b1;
                end
            end
            default: begin
                if (r_running && r_cont && r_flags[F_BLINK_CONT]) begin
                    n_flags[F_BLINK_ON]   = 1'b0;
                    n_flags[F_BLINK_CONT] = 1'b0;
                    n_ok                  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_cont        <= 1'b0;
            r_flags       <= '0;
            r_beep_stamp  <= '0;
            r_blink_stamp <= '0;
            r_buzzer      <= 1'b0;
            r_backlight   <= 1'b1;
        end else if (i_fire) begin
            r_running     <= n_running;
            r_cont        <= n_cont;
            r_flags       <= n_flags;
            r_beep_stamp  <= n_beep_stamp;
            r_blink_stamp <= n_blink_stamp;
            r_buzzer      <= n_buzzer;
            r_backlight   <= n_backlight;
        end
    end

    assign o_result.buzzer_level     = n_buzzer;
    assign o_result.backlight_level  = n_backlight;
    assign o_result.timer_running    = n_running;
    assign o_result.command_accepted = n_ok;

endmodule
`default_nettype wire

@@ src/buzzer_backlight_alarm_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buzzer and backlight alarm sequencer
// Drives a buzzer and a backlight from commands and millisecond timer ticks.
//
// The input channel carries one command or tick per transfer (kind, now_ms).
// The output channel returns one result per input item: buzzer level,
// backlight level, timer state and whether the command took effect.
// An accepted item lands in the input register; at the edge where the output
// advances, the core updates the effect state and the result register loads,
// and the result is then offered. With no stall at the output, one item per
// cycle is sustained.
// While the receiver stalls, the result register holds and one more item
// waits in the input register; stall goes back to the sender only then.
// Reset clears both registers, stops the timer, turns the buzzer off, lights
// the backlight and restores the default durations. Configuration writes
// take effect at the next edge and are meant for when no item is in flight.
// ----------------------------------------------------------------------------
module buzzer_backlight_alarm_sequencer
    import bbas_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [2:0]           i_in_kind,
    input  wire logic [TIME_W-1:0]    i_in_now_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_buzzer_level,
    output logic                      o_backlight_level,
    output logic                      o_timer_running,
    output logic                      o_command_accepted,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_result           r_out_result;

    logic              advance;
    logic              in_xfer;
    logic              fire;
    t_cfg              cfg;
    t_result           result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    bbas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bbas_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_kind   (r_in_kind),
        .i_now_ms (r_in_now),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_kind <= t_kind'(i_in_kind);
            r_in_now  <= i_in_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_result <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_buzzer_level     = r_out_result.buzzer_level;
    assign o_backlight_level  = r_out_result.backlight_level;
    assign o_timer_running    = r_out_result.timer_running;
    assign o_command_accepted = r_out_result.command_accepted;

endmodule
`default_nettype wire

@@ src/bbas_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "buzzer_backlight_alarm_sequencer_macros.svh"
// ----------------------------------------------------------------------------
// Alarm sequencer port checker
// Watches the top-level ports for transfer ordering and result behavior.
// ----------------------------------------------------------------------------
module bbas_checker
    import bbas_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [2:0]           i_in_kind,
    input wire logic [TIME_W-1:0]    i_in_now_ms,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic                 o_buzzer_level,
    input wire logic                 o_backlight_level,
    input wire logic                 o_timer_running,
    input wire logic                 o_command_accepted
);

    logic              in_xfer;
    logic              in_held;
    logic              held_result;
    logic [TIME_W+2:0] in_payload;
    logic [3:0]        out_payload;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign in_held     = i_in_valid && o_in_stall;
    assign held_result = o_out_valid && i_out_stall;
    assign in_payload  = {i_in_kind, i_in_now_ms};
    assign out_payload = {o_buzzer_level, o_backlight_level, o_timer_running,
                          o_command_accepted};

    // A stalled result keeps its payload until it is taken.
    `BBAS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, held_result, o_out_valid && $stable(out_payload))

    // A stalled input transfer keeps its payload until it is taken.
    `BBAS_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, in_held, i_in_valid && $stable(in_payload))

    // Every input transfer has a result on offer after the input and result registers.
    `BBAS_ASSERT_NOW(a_result_follows, i_clk, i_rst_n, in_xfer, ##2 o_out_valid)

    // No result is on offer in the cycle after reset is released.
    `BBAS_ASSERT_ALWAYS(a_reset_empty, i_clk, $rose(i_rst_n), !o_out_valid)

    // The input side is only stalled while a result is held back.
    `BBAS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, held_result)

endmodule

bind buzzer_backlight_alarm_sequencer bbas_checker u_bbas_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_in_kind          (i_in_kind),
    .i_in_now_ms        (i_in_now_ms),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_buzzer_level     (o_buzzer_level),
    .o_backlight_level  (o_backlight_level),
    .o_timer_running    (o_timer_running),
    .o_command_accepted (o_command_accepted)
);
`default_nettype wire
